### rtl/i2csr_pkg.sv
// ----------------------------------------------------------------------------
// i2csr_pkg
// Shared types and codes for the two-wire slave RAM byte engine.
// ----------------------------------------------------------------------------
package i2csr_pkg;

    localparam int RamDepth = 256;
    localparam int AddrW    = $clog2(RamDepth);

    localparam logic [2:0] REQ_START    = 3'd0;
    localparam logic [2:0] REQ_STOP     = 3'd1;
    localparam logic [2:0] REQ_ADDR     = 3'd2;
    localparam logic [2:0] REQ_DATA     = 3'd3;
    localparam logic [2:0] REQ_TX_START = 3'd4;
    localparam logic [2:0] REQ_TX_END   = 3'd5;
    localparam logic [2:0] REQ_BD_READ  = 3'd6;
    localparam logic [2:0] REQ_BD_WRITE = 3'd7;

    localparam logic [7:0] DEV_ADDR = 8'hA0;

    typedef logic [2:0]       req_type_t;
    typedef logic [7:0]       byte_t;
    typedef logic [AddrW-1:0] addr_t;

    typedef struct packed {
        logic  ack;
        byte_t ptr;
        logic  rd;
        logic  wr;
        addr_t addr;
        byte_t wdata;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

### rtl/i2csr_req_if.sv
// ----------------------------------------------------------------------------
// i2csr_req_if
// Request channel: bus event beats into the engine.
// ----------------------------------------------------------------------------
interface i2csr_req_if;
    import i2csr_pkg::*;

    logic      valid;
    logic      ready;
    req_type_t req_type;
    byte_t     byte_in;
    addr_t     ram_index;

    modport source (output valid, output req_type, output byte_in, output ram_index,
                     input ready);
    modport sink   (input valid, input req_type, input byte_in, input ram_index,
                     output ready);
endinterface

### rtl/i2csr_rsp_if.sv
// ----------------------------------------------------------------------------
// i2csr_rsp_if
// Response channel: one result beat per request.
// ----------------------------------------------------------------------------
interface i2csr_rsp_if;
    import i2csr_pkg::*;

    logic  valid;
    logic  ready;
    logic  ack;
    byte_t read_data;
    byte_t pointer_now;

    modport source (output valid, output ack, output read_data, output pointer_now,
                     input ready);
    modport sink   (input valid, input ack, input read_data, input pointer_now,
                     output ready);
endinterface

### rtl/i2csr_front.sv
// ----------------------------------------------------------------------------
// i2csr_front
// Event decoder: tracks bus phase and register pointer, emits RAM ops.
// ----------------------------------------------------------------------------
module i2csr_front (
    input  logic            clk,
    input  logic            rst_n,
    i2csr_req_if.sink       req,
    input  i2csr_pkg::qstat_t qstat,
    output logic            push,
    output i2csr_pkg::op_t  op
);
    import i2csr_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_PTR     = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_TXSTART = 3'd3;
    localparam logic [2:0] PH_TXEND   = 3'd4;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    byte_t      ptr_reg;
    byte_t      ptr_next;

    assign req.ready = !qstat.full;
    assign push      = req.valid && req.ready;

    always_comb
    begin
        phase_next = phase_reg;
        ptr_next   = ptr_reg;
        op.ack     = 1'b0;
        op.rd      = 1'b0;
        op.wr      = 1'b0;
        op.addr    = ptr_reg;
        op.wdata   = req.byte_in;
        case (req.req_type)
            REQ_START, REQ_STOP:
            begin
                phase_next = PH_IDLE;
                op.ack     = 1'b1;
            end
            REQ_ADDR:
            begin
                if (phase_reg == PH_IDLE && req.byte_in[7:1] == DEV_ADDR[7:1])
                begin
                    phase_next = req.byte_in[0] ? PH_TXSTART : PH_PTR;
                    op.ack     = 1'b1;
                end
            end
            REQ_DATA:
            begin
                if (phase_reg == PH_PTR)
                begin
                    ptr_next   = req.byte_in;
                    phase_next = PH_DATA;
                    op.ack     = 1'b1;
                end
                else if (phase_reg == PH_DATA)
                begin
                    op.wr    = 1'b1;
                    ptr_next = ptr_reg + 8'd1;
                    op.ack   = 1'b1;
                end
            end
            REQ_TX_START:
            begin
                if (phase_reg == PH_TXSTART)
                begin
                    op.rd      = 1'b1;
                    phase_next = PH_TXEND;
                    op.ack     = 1'b1;
                end
            end
            REQ_TX_END:
            begin
                if (phase_reg == PH_TXEND)
                begin
                    ptr_next   = ptr_reg + 8'd1;
                    phase_next = PH_TXSTART;
                    op.ack     = 1'b1;
                end
            end
            REQ_BD_READ:
            begin
                op.rd   = 1'b1;
                op.addr = req.ram_index;
                op.ack  = 1'b1;
            end
            REQ_BD_WRITE:
            begin
                op.wr   = 1'b1;
                op.addr = req.ram_index;
                op.ack  = 1'b1;
            end
            default:
            begin
                op.ack = 1'b0;
            end
        endcase
        op.ptr = ptr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ptr_reg   <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            ptr_reg   <= ptr_next;
        end
    end

endmodule

### rtl/i2csr_queue.sv
// ----------------------------------------------------------------------------
// i2csr_queue
// Two-entry queue of RAM ops between decoder and RAM side.
// ----------------------------------------------------------------------------
module i2csr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  i2csr_pkg::op_t     din,
    input  logic               pop,
    output i2csr_pkg::op_t     dout,
    output i2csr_pkg::qstat_t  qstat
);
    import i2csr_pkg::*;

    op_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign dout        = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/i2csr_back.sv
// ----------------------------------------------------------------------------
// i2csr_back
// RAM side: executes queued ops and holds the result beat.
// ----------------------------------------------------------------------------
module i2csr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  i2csr_pkg::op_t    op,
    input  i2csr_pkg::qstat_t qstat,
    output logic              pop,
    i2csr_rsp_if.source       rsp
);
    import i2csr_pkg::*;

    byte_t               mem [RamDepth];
    logic [RamDepth-1:0] written_reg;
    logic                out_valid_reg;
    logic                ack_reg;
    byte_t               ptr_reg;
    logic                rd_reg;
    logic                hit_reg;
    byte_t               rdata_reg;

    assign pop = !qstat.empty && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk)
    begin
        if (pop && op.wr)
        begin
            mem[op.addr] <= op.wdata;
        end
        if (pop && op.rd)
        begin
            rdata_reg <= mem[op.addr];
        end
        if (pop)
        begin
            ack_reg <= op.ack;
            ptr_reg <= op.ptr;
            rd_reg  <= op.rd;
            hit_reg <= written_reg[op.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && op.wr)
            begin
                written_reg[op.addr] <= 1'b1;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ack         = ack_reg;
    assign rsp.pointer_now = ptr_reg;
    assign rsp.read_data   = (rd_reg && hit_reg) ? rdata_reg : 8'd0;

endmodule

### rtl/i2c_slave_ram_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_slave_ram_byte_engine
// Two-wire slave byte engine with 256-byte RAM and auto-increment pointer.
// Result path: a taken request beat is queued, executed on pop and its result
// is registered; one beat per cycle unless rsp stalls, per the single RAM port.
// Reset: phase idle, pointer zero, RAM reads zero through per-byte written
// flags cleared at once; no clearing pass, requests taken right after reset.
// ----------------------------------------------------------------------------
module i2c_slave_ram_byte_engine (
    input  logic        clk,
    input  logic        rst_n,
    i2csr_req_if.sink   req,
    i2csr_rsp_if.source rsp
);
    import i2csr_pkg::*;

    op_t    fe_op;
    op_t    q_op;
    qstat_t qstat;
    logic   push;
    logic   pop;

    i2csr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .qstat (qstat),
        .push  (push),
        .op    (fe_op)
    );

    i2csr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (fe_op),
        .pop   (pop),
        .dout  (q_op),
        .qstat (qstat)
    );

    i2csr_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (q_op),
        .qstat (qstat),
        .pop   (pop),
        .rsp   (rsp)
    );

    a_start_stop_ack: assert property (@(posedge clk) disable iff (!rst_n)
        push && (req.req_type == REQ_START || req.req_type == REQ_STOP) |-> fe_op.ack)
        else $error("start or stop beat not acknowledged");

    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.empty && !rsp.valid |=> rsp.valid)
        else $error("queued op not moved to result register");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-wire slave RAM byte engine. Bus events
// (start/stop, target address, data, transmit start/end, backdoor access)
// are driven from a queue. A cycle-free model of phase, pointer and RAM
// predicts each response beat, and the monitor compares it field by field.
// Runs directed corner cases, then mostly well-formed write and read
// transfers with noise, under several valid/ready idling mixes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2csr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_PTR, PH_DATA, PH_TX_START, PH_TX_END
    } link_phase_t;

    typedef struct packed {
        req_type_t kind;
        byte_t     data;
        addr_t     idx;
    } bus_event_t;

    typedef struct packed {
        logic  ack;
        byte_t rdata;
        byte_t ptr;
    } rsp_beat_t;

    localparam int RandomPerPhase = 406;

    logic clk;
    logic rst_n;

    i2csr_req_if req_ch ();
    i2csr_rsp_if rsp_ch ();

    i2c_slave_ram_byte_engine i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    bus_event_t  event_q[$];
    rsp_beat_t   response_q[$];
    link_phase_t link_phase;
    byte_t       ptr_mirror;
    byte_t       ram_mirror [RamDepth];
    int          src_idle_pct;
    int          snk_stall_pct;
    int          events_added;
    int          errors;

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_START;
        req_ch.byte_in = '0;
        req_ch.ram_index = '0;
        rsp_ch.ready = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        events_added = 0;
        errors = 0;
        link_phase = PH_IDLE;
        ptr_mirror = '0;
        foreach (ram_mirror[i]) ram_mirror[i] = '0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #400us;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic rsp_beat_t engine_response(bus_event_t ev);
        rsp_beat_t r;
        r = '0;
        case (ev.kind)
            REQ_START, REQ_STOP:
            begin
                link_phase = PH_IDLE;
                r.ack = 1'b1;
            end
            REQ_ADDR:
            begin
                if (link_phase == PH_IDLE && (ev.data & 8'hFE) == (DEV_ADDR & 8'hFE))
                begin
                    link_phase = ev.data[0] ? PH_TX_START : PH_PTR;
                    r.ack = 1'b1;
                end
            end
            REQ_DATA:
            begin
                if (link_phase == PH_PTR)
                begin
                    ptr_mirror = ev.data;
                    link_phase = PH_DATA;
                    r.ack = 1'b1;
                end
                else if (link_phase == PH_DATA)
                begin
                    ram_mirror[ptr_mirror] = ev.data;
                    ptr_mirror = ptr_mirror + 8'd1;
                    r.ack = 1'b1;
                end
            end
            REQ_TX_START:
            begin
                if (link_phase == PH_TX_START)
                begin
                    r.rdata = ram_mirror[ptr_mirror];
                    link_phase = PH_TX_END;
                    r.ack = 1'b1;
                end
            end
            REQ_TX_END:
            begin
                if (link_phase == PH_TX_END)
                begin
                    ptr_mirror = ptr_mirror + 8'd1;
                    link_phase = PH_TX_START;
                    r.ack = 1'b1;
                end
            end
            REQ_BD_READ:
            begin
                r.rdata = ram_mirror[ev.idx];
                r.ack = 1'b1;
            end
            default:
            begin
                ram_mirror[ev.idx] = ev.data;
                r.ack = 1'b1;
            end
        endcase
        r.ptr = ptr_mirror;
        return r;
    endfunction

    // driver: predict on the accepting edge, then load the next beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                response_q.push_back(engine_response('{req_ch.req_type, req_ch.byte_in,
                                                       req_ch.ram_index}));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (event_q.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    req_ch.req_type  <= event_q[0].kind;
                    req_ch.byte_in   <= event_q[0].data;
                    req_ch.ram_index <= event_q[0].idx;
                    req_ch.valid     <= 1'b1;
                    void'(event_q.pop_front());
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (response_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response beat, expected none, actual %0h/%0h/%0h",
                             $time, rsp_ch.ack, rsp_ch.read_data, rsp_ch.pointer_now);
                end
                else
                begin
                    check_field("ack", response_q[0].ack, rsp_ch.ack);
                    check_field("read_data", response_q[0].rdata, rsp_ch.read_data);
                    check_field("pointer_now", response_q[0].ptr, rsp_ch.pointer_now);
                    void'(response_q.pop_front());
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    function automatic byte_t any_byte();
        return byte_t'($urandom_range(255));
    endfunction

    task automatic add_event(req_type_t kind, byte_t data, addr_t idx);
        event_q.push_back('{kind, data, idx});
        events_added++;
    endtask

    task automatic add_ctrl(req_type_t kind);
        add_event(kind, any_byte(), any_byte());
    endtask

    task automatic add_write_transfer();
        int n;
        n = $urandom_range(0, 8);
        add_ctrl(REQ_START);
        add_event(REQ_ADDR, DEV_ADDR, any_byte());
        add_event(REQ_DATA, ($urandom_range(3) == 0) ? byte_t'($urandom_range(248, 255))
                                                     : any_byte(), any_byte());
        repeat (n) add_event(REQ_DATA, any_byte(), any_byte());
        add_ctrl(REQ_STOP);
    endtask

    task automatic add_read_transfer();
        int n;
        n = $urandom_range(1, 8);
        add_ctrl(REQ_START);
        if ($urandom_range(1))
        begin
            add_event(REQ_ADDR, DEV_ADDR, any_byte());
            add_event(REQ_DATA, any_byte(), any_byte());
            add_ctrl(REQ_START);
        end
        add_event(REQ_ADDR, DEV_ADDR | 8'h01, any_byte());
        repeat (n)
        begin
            add_ctrl(REQ_TX_START);
            add_ctrl(REQ_TX_END);
        end
        if ($urandom_range(1))
            add_ctrl(REQ_TX_START);
        add_ctrl(REQ_STOP);
    endtask

    task automatic add_noise();
        byte_t b;
        repeat ($urandom_range(1, 4))
        begin
            b = any_byte();
            if ($urandom_range(2) == 0)
                b = DEV_ADDR ^ (8'h01 << $urandom_range(7));
            add_event(req_type_t'($urandom_range(7)), b, any_byte());
        end
    endtask

    task automatic add_random_traffic();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            add_write_transfer();
        else if (pick < 75)
            add_read_transfer();
        else if (pick < 85)
            add_event($urandom_range(1) ? REQ_BD_READ : REQ_BD_WRITE, any_byte(), any_byte());
        else
            add_noise();
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (event_q.size() > 0 || req_ch.valid || response_q.size() > 0);
    endtask

    task automatic add_directed();
        add_ctrl(REQ_TX_START);
        add_event(REQ_DATA, 8'h5A, 8'h00);
        add_ctrl(REQ_TX_END);
        add_event(REQ_ADDR, 8'h42, 8'h00);
        add_event(REQ_ADDR, 8'hA1, 8'hFF);
        add_event(REQ_ADDR, 8'hA0, 8'h00);
        add_event(REQ_DATA, 8'h33, 8'h00);
        add_ctrl(REQ_TX_END);
        add_ctrl(REQ_TX_START);
        add_ctrl(REQ_TX_START);
        add_ctrl(REQ_TX_END);
        add_ctrl(REQ_STOP);
        add_ctrl(REQ_START);
        add_event(REQ_ADDR, 8'hA0, 8'h00);
        add_ctrl(REQ_TX_START);
        add_event(REQ_DATA, 8'hFF, 8'h00);
        add_event(REQ_DATA, 8'h00, 8'hFF);
        add_event(REQ_DATA, 8'hFF, 8'h00);
        add_ctrl(REQ_STOP);
        add_event(REQ_BD_WRITE, 8'h55, 8'h00);
        add_event(REQ_BD_READ, 8'h00, 8'h00);
        add_event(REQ_BD_READ, 8'hFF, 8'hFF);
        add_event(REQ_BD_WRITE, 8'hFF, 8'hFF);
        add_event(REQ_BD_READ, 8'h00, 8'hFF);
        add_event(REQ_ADDR, 8'h21, 8'h00);
    endtask

    initial
    begin
        int target;
        wait (rst_n === 1'b1);
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
                default: begin src_idle_pct = 23; snk_stall_pct = 23; end
            endcase
            if (ph == 0)
                add_directed();
            for (int half = 0; half < 2; half++)
            begin
                target = events_added + RandomPerPhase / 2;
                while (events_added < target)
                    add_random_traffic();
                // hold off until every response is back
                wait_drained();
            end
        end
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/i2csr_pkg.sv
rtl/i2csr_req_if.sv
rtl/i2csr_rsp_if.sv
rtl/i2csr_front.sv
rtl/i2csr_queue.sv
rtl/i2csr_back.sv
rtl/i2c_slave_ram_byte_engine.sv
verif/tb.sv
